### rtl/core/smbw_pkg.sv
package smbw_pkg;

   // brush geometry
   localparam int RADIUS     = 15;
   localparam int SIDE       = 2 * RADIUS + 1;
   localparam int CELLS      = SIDE * SIDE;
   localparam int MASK_SIDE  = RADIUS + 1;
   localparam int MASK_CELLS = MASK_SIDE * MASK_SIDE;

   // widths
   localparam int CHAN_W     = 8;
   localparam int POS_W      = $clog2(SIDE);
   localparam int IDX_W      = $clog2(CELLS);
   localparam int MASK_IDX_W = $clog2(MASK_CELLS);
   localparam int MASK_W     = 17;
   localparam int WIN_IDX_W  = 10;
   localparam int W_W        = 24;
   localparam int NUM_W      = 32;

   // fixed point constants
   localparam longint unsigned ONE_Q16  = 64'd65536;
   localparam longint unsigned MASK_DIV = longint'(RADIUS) * longint'(RADIUS) * ONE_Q16;
   localparam longint unsigned RAD_Q16  = longint'(RADIUS) * ONE_Q16;
   localparam logic [W_W-1:0] BLEND_K   = W_W'(255 * 65536);

   // position limits
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(SIDE - 1);
   localparam logic [POS_W-1:0] RADIUS_POS = POS_W'(RADIUS);
   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(CELLS - 1);

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } paint_type;

   localparam paint_type PAINT_BLACK = '{alpha: 8'hFF, red: 8'h00, green: 8'h00, blue: 8'h00};

   // stage strobes from the sequencer to the blend datapath
   typedef struct packed {
      logic load_mask;
      logic load_weight;
      logic load_mix;
   } blend_ctrl_type;

   typedef logic [MASK_W-1:0] falloff_rom_type [MASK_CELLS];

   // quadratic falloff mask, Q1.16, indexed by row offset * MASK_SIDE + column offset
   function automatic falloff_rom_type build_falloff();
      falloff_rom_type rom;
      longint unsigned v;
      longint unsigned d;
      longint unsigned trial;
      longint unsigned t;
      for (int i = 0; i < MASK_SIDE; i++) begin
         for (int j = 0; j < MASK_SIDE; j++) begin
            v = longint'(i * i + j * j) << 32;
            d = 0;
            // floor square root, one result bit per step
            for (int b = 31; b >= 0; b--) begin
               trial = d | (64'd1 << b);
               if (trial * trial <= v) begin
                  d = trial;
               end
            end
            t = (d < RAD_Q16) ? RAD_Q16 - d : 64'd0;
            rom[i * MASK_SIDE + j] = MASK_W'((t * t + MASK_DIV / 2) / MASK_DIV);
         end
      end
      return rom;
   endfunction

   localparam falloff_rom_type FALLOFF_ROM = build_falloff();

endpackage

### rtl/core/smbw_ram.sv
module smbw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/smbw_blend.sv
module smbw_blend import smbw_pkg::*; (
   input  logic                  clock,
   input  blend_ctrl_type        ctrl,
   input  logic [MASK_IDX_W-1:0] mask_idx,
   input  logic [CHAN_W-1:0]     pix_red,
   input  logic [CHAN_W-1:0]     pix_green,
   input  logic [CHAN_W-1:0]     pix_blue,
   input  paint_type             paint,
   output logic [CHAN_W-1:0]     res_red,
   output logic [CHAN_W-1:0]     res_green,
   output logic [CHAN_W-1:0]     res_blue
);

   logic [MASK_W-1:0] mask_ff;
   logic [CHAN_W-1:0] pix_red_ff;
   logic [CHAN_W-1:0] pix_green_ff;
   logic [CHAN_W-1:0] pix_blue_ff;
   logic [W_W-1:0]    weight_ff;
   paint_type         paint_ff;
   logic [NUM_W-1:0]  num_red_ff;
   logic [NUM_W-1:0]  num_green_ff;
   logic [NUM_W-1:0]  num_blue_ff;

   // (K - w) * pixel + w * paint + K / 2
   function automatic logic [NUM_W-1:0] mix_sum(logic [W_W-1:0] w, logic [CHAN_W-1:0] pix,
                                                logic [CHAN_W-1:0] pnt);
      logic [NUM_W-1:0] keep;
      logic [NUM_W-1:0] take;
      keep = NUM_W'(BLEND_K - w) * NUM_W'(pix);
      take = NUM_W'(w) * NUM_W'(pnt);
      return keep + take + NUM_W'(BLEND_K / 2);
   endfunction

   // divide by 255 * 2^16: drop 16 bits, then reciprocal of 255 with correction
   function automatic logic [CHAN_W-1:0] div_k(logic [NUM_W-1:0] num);
      logic [15:0] q;
      logic [16:0] s;
      q = num[NUM_W-1 -: 16];
      s = 17'(q) + 17'(q[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   // mask lookup and pixel capture at accept, weight, then channel mix
   always_ff @(posedge clock) begin
      if (ctrl.load_mask) begin
         mask_ff      <= FALLOFF_ROM[mask_idx];
         pix_red_ff   <= pix_red;
         pix_green_ff <= pix_green;
         pix_blue_ff  <= pix_blue;
      end
      if (ctrl.load_weight) begin
         weight_ff <= W_W'(mask_ff) * W_W'(paint.alpha);
         paint_ff  <= paint;
      end
      if (ctrl.load_mix) begin
         num_red_ff   <= mix_sum(weight_ff, pix_red_ff, paint_ff.red);
         num_green_ff <= mix_sum(weight_ff, pix_green_ff, paint_ff.green);
         num_blue_ff  <= mix_sum(weight_ff, pix_blue_ff, paint_ff.blue);
      end
   end

   // rounded quotient
   assign res_red   = div_k(num_red_ff);
   assign res_green = div_k(num_green_ff);
   assign res_blue  = div_k(num_blue_ff);

endmodule

### rtl/core/smudge_brush_window_blend_unit.sv
// channel | ports                                      | direction
// req     | req_valid req_stall req_func ... req_window_end | in, stall out
// rsp     | rsp_valid rsp_stall rsp_out_* rsp_window_index  | out, stall in
//
// pick-up items and items outside the canvas finish at accept (one paint store write)
// smudge items inside the canvas go through accept and store read, weight
// multiply, channel mix, divide and write-back; the paint store read-modify-write
// sets this order, and req_stall stays high until write-back
// after reset a clearing pass writes opaque black to all 961 store entries,
// req_stall stays high for the whole pass
// a held result waits in the output register; a further smudge item waits at
// write-back until that register is free
module smudge_brush_window_blend_unit import smbw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic                 req_inside_canvas,
   input  logic [CHAN_W-1:0]    req_pix_red,
   input  logic [CHAN_W-1:0]    req_pix_green,
   input  logic [CHAN_W-1:0]    req_pix_blue,
   input  logic [CHAN_W-1:0]    req_pix_alpha,
   input  logic                 req_window_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAN_W-1:0]    rsp_out_red,
   output logic [CHAN_W-1:0]    rsp_out_green,
   output logic [CHAN_W-1:0]    rsp_out_blue,
   output logic [WIN_IDX_W-1:0] rsp_window_index
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WEIGHT,
      ST_MIX,
      ST_DONE
   } state_type;

   state_type             state_ff,    state_in;
   logic [IDX_W-1:0]      clr_ff,      clr_in;
   logic [POS_W-1:0]      row_ff,      row_in;
   logic [POS_W-1:0]      col_ff,      col_in;
   logic [IDX_W-1:0]      idx_ff,      idx_in;
   logic [IDX_W-1:0]      item_idx_ff, item_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]     rsp_red_ff,   rsp_red_in;
   logic [CHAN_W-1:0]     rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0]     rsp_blue_ff,  rsp_blue_in;
   logic [WIN_IDX_W-1:0]  rsp_index_ff, rsp_index_in;

   logic                  req_accept;
   logic                  blend_item;
   logic                  rsp_free;
   logic                  done_fire;
   logic [POS_W-1:0]      row_off;
   logic [POS_W-1:0]      col_off;
   logic [MASK_IDX_W-1:0] mask_idx;
   blend_ctrl_type        blend_ctrl;
   logic [CHAN_W-1:0]     res_red;
   logic [CHAN_W-1:0]     res_green;
   logic [CHAN_W-1:0]     res_blue;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   paint_type             wr_data;
   paint_type             rd_data;

   // handshake
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign blend_item = req_func && req_inside_canvas;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign done_fire  = (state_ff == ST_DONE) && rsp_free;

   // mask position from distance to the window center
   assign row_off  = (row_ff > RADIUS_POS) ? row_ff - RADIUS_POS : RADIUS_POS - row_ff;
   assign col_off  = (col_ff > RADIUS_POS) ? col_ff - RADIUS_POS : RADIUS_POS - col_ff;
   assign mask_idx = MASK_IDX_W'(row_off) * MASK_IDX_W'(MASK_SIDE) + MASK_IDX_W'(col_off);

   assign blend_ctrl.load_mask   = req_accept && blend_item;
   assign blend_ctrl.load_weight = (state_ff == ST_WEIGHT);
   assign blend_ctrl.load_mix    = (state_ff == ST_MIX);

   // paint store write source
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = PAINT_BLACK;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
         end
         ST_IDLE: begin
            if (req_accept && !blend_item) begin
               wr_en = 1'b1;
               if (req_inside_canvas) begin
                  wr_data = '{alpha: req_pix_alpha, red: req_pix_red,
                              green: req_pix_green, blue: req_pix_blue};
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               wr_en   = 1'b1;
               wr_addr = item_idx_ff;
               wr_data = '{alpha: ALPHA_OPAQUE, red: res_red, green: res_green, blue: res_blue};
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer, position counters and output register next values
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      idx_in       = idx_ff;
      item_idx_in  = item_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_index_in = rsp_index_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               item_idx_in = idx_ff;
               if (blend_item) begin
                  state_in = ST_WEIGHT;
               end
               if (req_window_end) begin
                  row_in = '0;
                  col_in = '0;
                  idx_in = '0;
               end else begin
                  idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
                  if (col_ff == POS_LAST) begin
                     col_in = '0;
                     row_in = (row_ff == POS_LAST) ? '0 : row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
         end
         ST_WEIGHT: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_red_in   = res_red;
               rsp_green_in = res_green;
               rsp_blue_in  = res_blue;
               rsp_index_in = WIN_IDX_W'(item_idx_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_idx_ff  <= item_idx_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_red_ff;
   assign rsp_out_green    = rsp_green_ff;
   assign rsp_out_blue     = rsp_blue_ff;
   assign rsp_window_index = rsp_index_ff;

   // paint store
   smbw_ram #(
      .WIDTH ($bits(paint_type)),
      .DEPTH (CELLS)
   ) u_paint_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (blend_ctrl.load_mask),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // blend datapath
   smbw_blend u_blend (
      .clock     (clock),
      .ctrl      (blend_ctrl),
      .mask_idx  (mask_idx),
      .pix_red   (req_pix_red),
      .pix_green (req_pix_green),
      .pix_blue  (req_pix_blue),
      .paint     (rd_data),
      .res_red   (res_red),
      .res_green (res_green),
      .res_blue  (res_blue)
   );

endmodule

### rtl/core/smbw_checker.sv
module smbw_checker import smbw_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_func,
   input logic                 req_inside_canvas,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [CHAN_W-1:0]    rsp_out_red,
   input logic [CHAN_W-1:0]    rsp_out_green,
   input logic [CHAN_W-1:0]    rsp_out_blue,
   input logic [WIN_IDX_W-1:0] rsp_window_index
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red) &&
      $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_window_index))
      else $error("held result changed");

   // clearing pass keeps the input closed right after reset
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open during store clearing");

   // a smudge item inside the canvas keeps the input stalled after it is accepted
   a_smudge_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func && req_inside_canvas |=> req_stall)
      else $error("smudge item did not hold the input");

   // a pick-up or outside item leaves the input open in the cycle after it is accepted
   a_pickup_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !(req_func && req_inside_canvas) |=> !req_stall)
      else $error("pick-up item held the input");

   // a new result only comes out of a write-back cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a smudge item in flight");

endmodule

bind smudge_brush_window_blend_unit smbw_checker u_checker (.*);

### sim/testbench.sv
module testbench;
   import smbw_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int RESET_LEN   = 4;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_LEN    = 400;
   localparam int DRAIN_WAIT  = 20;
   localparam int PHASE_ITEMS = 40;

   localparam logic FUNC_PICKUP = 1'b0;
   localparam logic FUNC_SMUDGE = 1'b1;

   localparam longint unsigned BLEND_SCALE = 64'd255 * 64'd65536;

   typedef struct packed {
      logic              func;
      logic              on_canvas;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              wend;
   } pixel_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0]    red;
      logic [CHAN_W-1:0]    green;
      logic [CHAN_W-1:0]    blue;
      logic [WIN_IDX_W-1:0] window_index;
   } blend_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = 1'b0;
   logic                 req_inside_canvas = 1'b0;
   logic [CHAN_W-1:0]    req_pix_red = '0;
   logic [CHAN_W-1:0]    req_pix_green = '0;
   logic [CHAN_W-1:0]    req_pix_blue = '0;
   logic [CHAN_W-1:0]    req_pix_alpha = '0;
   logic                 req_window_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CHAN_W-1:0]    rsp_out_red;
   logic [CHAN_W-1:0]    rsp_out_green;
   logic [CHAN_W-1:0]    rsp_out_blue;
   logic [WIN_IDX_W-1:0] rsp_window_index;

   // brush model state
   paint_type         paint_mem [CELLS];
   logic [MASK_W-1:0] falloff_q16 [MASK_CELLS];
   int unsigned       brush_row;
   int unsigned       brush_col;
   blend_result_type  pending_blends [$];

   int     send_idle_pct = 0;
   int     stall_pct = 0;
   logic   hold_go = 1'b0;
   int     hold_left = 0;
   int     fail_count = 0;
   longint cycle_count = 0;

   smudge_brush_window_blend_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_inside_canvas (req_inside_canvas),
      .req_pix_red       (req_pix_red),
      .req_pix_green     (req_pix_green),
      .req_pix_blue      (req_pix_blue),
      .req_pix_alpha     (req_pix_alpha),
      .req_window_end    (req_window_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_window_index  (rsp_window_index)
   );

   // clock
   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // quadratic falloff value for a row and column offset, Q1.16
   function automatic logic [MASK_W-1:0] falloff_entry(int i, int j);
      longint unsigned v;
      longint unsigned root;
      longint unsigned probe;
      longint unsigned t;
      longint unsigned r;
      longint unsigned div;
      v = 64'(i * i + j * j) << 32;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      // bit-pair integer square root
      while (probe != 0) begin
         if (v >= root + probe) begin
            v -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      r = 64'(RADIUS) * 64'd65536;
      div = 64'(RADIUS * RADIUS) * 64'd65536;
      t = (root < r) ? r - root : 64'd0;
      return MASK_W'((t * t + div / 2) / div);
   endfunction

   // rounded weighted mix of one channel
   function automatic logic [CHAN_W-1:0] channel_mix(longint unsigned w,
                                                     logic [CHAN_W-1:0] pix,
                                                     logic [CHAN_W-1:0] paint);
      longint unsigned num;
      num = (BLEND_SCALE - w) * 64'(pix) + w * 64'(paint) + BLEND_SCALE / 2;
      return CHAN_W'(num / BLEND_SCALE);
   endfunction

   // apply one accepted item to the brush model, queue the blended pixel if any
   function automatic void blend_pixel(pixel_item_type it);
      int unsigned      pos_idx;
      int unsigned      dr;
      int unsigned      dc;
      longint unsigned  w;
      paint_type        paint;
      blend_result_type res;
      pos_idx = brush_row * SIDE + brush_col;
      paint = paint_mem[pos_idx];
      if (!it.on_canvas) begin
         paint_mem[pos_idx] = PAINT_BLACK;
      end else if (it.func == FUNC_PICKUP) begin
         paint_mem[pos_idx] = '{alpha: it.alpha, red: it.red, green: it.green, blue: it.blue};
      end else begin
         dr = (brush_row > RADIUS) ? brush_row - RADIUS : RADIUS - brush_row;
         dc = (brush_col > RADIUS) ? brush_col - RADIUS : RADIUS - brush_col;
         w = 64'(falloff_q16[dr * MASK_SIDE + dc]) * 64'(paint.alpha);
         res.red = channel_mix(w, it.red, paint.red);
         res.green = channel_mix(w, it.green, paint.green);
         res.blue = channel_mix(w, it.blue, paint.blue);
         res.window_index = WIN_IDX_W'(pos_idx);
         pending_blends.insert(pending_blends.size(), res);
         paint_mem[pos_idx] = '{alpha: ALPHA_OPAQUE, red: res.red, green: res.green,
                                blue: res.blue};
      end
      // window position advance
      if (it.wend) begin
         brush_row = 0;
         brush_col = 0;
      end else begin
         brush_col++;
         if (brush_col >= SIDE) begin
            brush_col = 0;
            brush_row++;
            if (brush_row >= SIDE) brush_row = 0;
         end
      end
   endfunction

   function automatic pixel_item_type make_pixel(logic func, logic on_canvas,
                                                 logic [CHAN_W-1:0] red,
                                                 logic [CHAN_W-1:0] green,
                                                 logic [CHAN_W-1:0] blue,
                                                 logic [CHAN_W-1:0] alpha, logic wend);
      pixel_item_type it;
      it.func = func;
      it.on_canvas = on_canvas;
      it.red = red;
      it.green = green;
      it.blue = blue;
      it.alpha = alpha;
      it.wend = wend;
      return it;
   endfunction

   // channel value leaning on the extremes
   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   function automatic pixel_item_type rand_pixel(logic func, logic on_canvas, logic wend);
      return make_pixel(func, on_canvas, rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                        wend);
   endfunction

   // offer one item, hold it until accepted, then update the model
   task automatic send_item(input pixel_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_inside_canvas <= it.on_canvas;
      req_pix_red <= it.red;
      req_pix_green <= it.green;
      req_pix_blue <= it.blue;
      req_pix_alpha <= it.alpha;
      req_window_end <= it.wend;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      blend_pixel(it);
   endtask

   // stop sending and wait for every blended pixel to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_blends.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
   endtask

   // extremes, both modes, outside pixels and window end
   task automatic test_directed();
      // pick-up pass
      send_item(make_pixel(FUNC_PICKUP, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_item(make_pixel(FUNC_PICKUP, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      send_item(make_pixel(FUNC_PICKUP, 1'b0, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 1'b0));
      send_item(make_pixel(FUNC_SMUDGE, 1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
      send_item(make_pixel(FUNC_PICKUP, 1'b1, 8'h12, 8'h34, 8'h56, 8'h80, 1'b1));
      // smudge pass over that paint
      send_item(make_pixel(FUNC_SMUDGE, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      send_item(make_pixel(FUNC_SMUDGE, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_item(make_pixel(FUNC_SMUDGE, 1'b1, 8'h80, 8'h7F, 8'h01, 8'hFE, 1'b0));
      send_item(make_pixel(FUNC_SMUDGE, 1'b1, 8'h7F, 8'h80, 8'hFE, 8'h01, 1'b0));
      send_item(make_pixel(FUNC_SMUDGE, 1'b1, 8'hFF, 8'h00, 8'hAA, 8'h55, 1'b1));
      // second smudge over freshly written paint
      send_item(make_pixel(FUNC_SMUDGE, 1'b1, 8'h55, 8'hAA, 8'h00, 8'hFF, 1'b0));
      send_item(make_pixel(FUNC_SMUDGE, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_item(make_pixel(FUNC_SMUDGE, 1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1));
      wait_drained();
   endtask

   // one mixed pass over the whole window wrapping on its own, then smudge over that paint
   task automatic test_deep_window();
      for (int k = 0; k < CELLS; k++) begin
         send_item(rand_pixel($urandom_range(3) != 0, $urandom_range(19) != 0, 1'b0));
      end
      for (int k = 0; k < 20; k++) begin
         send_item(rand_pixel(FUNC_SMUDGE, 1'b1, k == 19));
      end
      wait_drained();
   endtask

   // short strokes: pick-up then smudge passes, with some noise and unclosed windows
   task automatic test_random_strokes(input int budget);
      int sent;
      int len;
      int passes;
      bit closed;
      sent = 0;
      while (sent < budget) begin
         len = $urandom_range(1, 24);
         if ($urandom_range(9) == 0) begin
            for (int k = 0; k < len; k++) begin
               send_item(rand_pixel(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    $urandom_range(15) == 0));
            end
            sent += len;
         end else begin
            passes = $urandom_range(2, 3);
            for (int p = 0; p < passes; p++) begin
               closed = $urandom_range(7) != 0;
               for (int k = 0; k < len; k++) begin
                  send_item(rand_pixel((p == 0) ? FUNC_PICKUP : FUNC_SMUDGE,
                                       $urandom_range(9) != 0, closed && k == len - 1));
               end
            end
            sent += passes * len;
         end
      end
      wait_drained();
   endtask

   // long receiver hold while smudge items keep coming, then a full drain and a closed smudge pass
   task automatic test_back_pressure();
      set_idling(0, 0);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      for (int k = 0; k < 40; k++) begin
         send_item(rand_pixel(FUNC_SMUDGE, 1'b1, 1'b0));
      end
      wait_drained();
      for (int k = 0; k < 20; k++) begin
         send_item(rand_pixel(FUNC_SMUDGE, 1'b1, k == 19));
      end
      wait_drained();
   endtask

   // receiver stall, with a counted long hold
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= hold_go || (hold_left > 1) || ($urandom_range(99) < stall_pct);
   end

   // compare each result with the oldest expected blend
   always @(posedge clock) begin
      blend_result_type exp_res;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_blends.size() == 0) begin
            $error("unexpected result at window_index %0d", rsp_window_index);
            fail_count++;
         end else begin
            exp_res = pending_blends.pop_front();
            if (rsp_out_red !== exp_res.red) begin
               $error("rsp_out_red expected %0d got %0d", exp_res.red, rsp_out_red);
               fail_count++;
            end
            if (rsp_out_green !== exp_res.green) begin
               $error("rsp_out_green expected %0d got %0d", exp_res.green, rsp_out_green);
               fail_count++;
            end
            if (rsp_out_blue !== exp_res.blue) begin
               $error("rsp_out_blue expected %0d got %0d", exp_res.blue, rsp_out_blue);
               fail_count++;
            end
            if (rsp_window_index !== exp_res.window_index) begin
               $error("rsp_window_index expected %0d got %0d", exp_res.window_index,
                      rsp_window_index);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // test sequence
   initial begin
      for (int c = 0; c < CELLS; c++) paint_mem[c] = PAINT_BLACK;
      for (int i = 0; i < MASK_SIDE; i++) begin
         for (int j = 0; j < MASK_SIDE; j++) falloff_q16[i * MASK_SIDE + j] = falloff_entry(i, j);
      end
      brush_row = 0;
      brush_col = 0;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_directed();
      test_deep_window();
      set_idling(0, 0);
      test_random_strokes(PHASE_ITEMS);
      set_idling(84, 0);
      test_random_strokes(PHASE_ITEMS);
      set_idling(0, 84);
      test_random_strokes(PHASE_ITEMS);
      set_idling(32, 32);
      test_random_strokes(PHASE_ITEMS);
      test_back_pressure();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_blends.size() != 0) begin
         $error("%0d expected results never arrived", pending_blends.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
